[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is high.
`define CC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Clocked check that also holds during reset.
`define CC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

[hw/rtl/cc20_pkg.sv]
// Shared types, constants and quarter-round helpers for the ChaCha20 block function.
package cc20_pkg;

   localparam int unsigned WORDS         = 16;
   localparam int unsigned LANES         = 4;
   localparam int unsigned DOUBLE_ROUNDS = 10;
   localparam int unsigned IDX_W         = $clog2(WORDS);
   localparam int unsigned DR_W          = $clog2(DOUBLE_ROUNDS);

   // Quarter-round rows: a, b, c, d.
   localparam logic [1:0] ROW_A = 2'd0;
   localparam logic [1:0] ROW_B = 2'd1;
   localparam logic [1:0] ROW_C = 2'd2;
   localparam logic [1:0] ROW_D = 2'd3;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ROUND,
      ST_OUT
   } state_type;

   // State word index of one row of a quarter round; diagonals shift column by row.
   function automatic logic [IDX_W-1:0] qr_idx(input logic diag, input logic [1:0] lane,
                                                 input logic [1:0] row);
      logic [1:0] col;
      col = diag ? lane + row : lane;
      return {row, col};
   endfunction

   // Rotate left by the amount of the given quarter-round line: 16, 12, 8, 7.
   function automatic logic [31:0] rotl_line(input logic [31:0] x, input logic [1:0] line);
      logic [31:0] r;
      case (line)
         2'd0:    r = {x[15:0], x[31:16]};
         2'd1:    r = {x[19:0], x[31:20]};
         2'd2:    r = {x[23:0], x[31:24]};
         default: r = {x[24:0], x[31:25]};
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/chacha20_block_function.sv]
// ChaCha20 block function: word loader, shared quarter-round line unit, result sequencer.
//
// Input channel (req_): the 16 words of the input state, word 0 first, one per transfer.
// req_stall is low only while words are being loaded; it goes high after word 15.
// Computation: a shared four-lane unit applies one quarter-round line (add, xor,
// rotate) to all four columns or all four diagonals each cycle; a double round runs the four
// column lines, then the four diagonal lines, and the block runs 10 double rounds.
// Result channel (rsp_): 16 words, each the input word plus its final working word
// mod 2^32, word 0 first; rsp_last_word marks word 15. The first result is loaded into the
// output register in ST_OUT after the rounds end, then one per cycle while rsp_stall stays low.
// A block passes through loading, the round loop and result output in turn, and no
// words of the next block are taken before its last result is loaded; the round loop
// through the shared unit takes the longest of the three phases.
// An output register holds a stalled result steady; while rsp_stall is high the
// sequencer waits, and loading of the next block may start as soon as the last
// result sits in the output register.
// Reset (synchronous, active high) returns to loading word 0 and drops rsp_valid;
// the word stores are not cleared.
module chacha20_block_function import cc20_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_in_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_word,
   output logic        rsp_last_word
);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       line_ff, line_in;
   logic             diag_ff, diag_in;
   logic [DR_W-1:0]  dround_ff, dround_in;

   logic [31:0]      in_ff   [WORDS];
   logic [31:0]      work_ff [WORDS];
   logic [31:0]      work_in [WORDS];

   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_word_ff, rsp_word_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             req_xfer;
   logic             out_load;

   logic [IDX_W-1:0] x_idx [LANES];
   logic [IDX_W-1:0] y_idx [LANES];
   logic [IDX_W-1:0] z_idx [LANES];
   logic [31:0]      x_new [LANES];
   logic [31:0]      z_new [LANES];

   assign req_stall     = (state_ff != ST_LOAD);
   assign req_xfer      = req_valid && !req_stall;
   assign out_load      = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_word  = rsp_word_ff;
   assign rsp_last_word = rsp_last_ff;

   // Shared line unit: even lines a+=b, d=rotl(d^a); odd lines c+=d, b=rotl(b^c)
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         x_idx[l] = qr_idx(diag_ff, 2'(l), line_ff[0] ? ROW_C : ROW_A);
         y_idx[l] = qr_idx(diag_ff, 2'(l), line_ff[0] ? ROW_D : ROW_B);
         z_idx[l] = qr_idx(diag_ff, 2'(l), line_ff[0] ? ROW_B : ROW_D);
         x_new[l] = work_ff[x_idx[l]] + work_ff[y_idx[l]];
         z_new[l] = rotl_line(work_ff[z_idx[l]] ^ x_new[l], line_ff);
      end
   end

   // Working state next value
   always_comb begin
      work_in = work_ff;
      if (req_xfer) begin
         work_in[cnt_ff] = req_in_word;
      end
      if (state_ff == ST_ROUND) begin
         for (int l = 0; l < LANES; l++) begin
            work_in[x_idx[l]] = x_new[l];
            work_in[z_idx[l]] = z_new[l];
         end
      end
   end

   // Sequencer: next state, counters and output register
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      line_in      = line_ff;
      diag_in      = diag_ff;
      dround_in    = dround_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_xfer) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == IDX_W'(WORDS - 1)) begin
                  state_in = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            line_in = line_ff + 1'b1;
            if (line_ff == 2'd3) begin
               diag_in = !diag_ff;
               if (diag_ff) begin
                  dround_in = dround_ff + 1'b1;
                  if (dround_ff == DR_W'(DOUBLE_ROUNDS - 1)) begin
                     dround_in = '0;
                     state_in  = ST_OUT;
                  end
               end
            end
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = in_ff[cnt_ff] + work_ff[cnt_ff];
               rsp_last_in  = (cnt_ff == IDX_W'(WORDS - 1));
               cnt_in       = cnt_ff + 1'b1;
               if (cnt_ff == IDX_W'(WORDS - 1)) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         line_ff      <= '0;
         diag_ff      <= 1'b0;
         dround_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         line_ff      <= line_in;
         diag_ff      <= diag_in;
         dround_ff    <= dround_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_ff[cnt_ff] <= req_in_word;
      end
      work_ff     <= work_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

[hw/rtl/cc20_check.sv]
// Port-level checker for the ChaCha20 block function, bound to the top level.
`include "assert_macros.svh"

module cc20_check (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_out_word,
   input logic        rsp_last_word
);

   // Reset drops any pending result.
   `CC_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid)

   // A stalled result holds its word and marker.
   `CC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_word) && $stable(rsp_last_word))

   // While words are taken in, only the last word of the previous block can wait.
   `CC_ASSERT(a_load_only_last, clock, reset, rsp_valid && !req_stall |-> rsp_last_word)

   // Once the last word leaves, rsp_valid drops.
   `CC_ASSERT(a_gap_after_last, clock, reset, rsp_valid && rsp_last_word && !rsp_stall |=> !rsp_valid)

endmodule

bind chacha20_block_function cc20_check u_cc20_check (.*);

[tb/sv/tb_chacha20_block_function.sv]
// Self-checking testbench for the ChaCha20 block function: word loading, rounds, keystream.
module tb_chacha20_block_function import cc20_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [WORDS-1:0][31:0] state16_type;

   typedef struct packed {
      logic [31:0] out_word;
      logic        last_word;
   } keystream_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_in_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_out_word;
   logic        rsp_last_word;

   // Words of the block being loaded, and the keystream words still to come
   state16_type          loaded_words;
   int                   load_index = 0;
   keystream_word_type   keystream_q[$];
   int                   fail_count = 0;

   // Idle rates in percent: sender gaps and receiver stalls
   int gap_pct = 0;
   int stall_pct = 0;

   chacha20_block_function dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_word   (req_in_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_word  (rsp_out_word),
      .rsp_last_word (rsp_last_word)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   // Full block function: 10 double rounds, then add the initial words back in
   function automatic state16_type chacha_keystream(input state16_type init);
      state16_type x;
      int          a, b, c, d, lane, diag;
      x = init;
      for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
         // q 0..3 are the columns, q 4..7 the diagonals
         for (int q = 0; q < 8; q++) begin
            lane = q % 4;
            diag = q / 4;
            a = lane;
            b = 4 + (lane + diag) % 4;
            c = 8 + (lane + 2 * diag) % 4;
            d = 12 + (lane + 3 * diag) % 4;
            x[a] = x[a] + x[b]; x[d] = rotl32(x[d] ^ x[a], 16);
            x[c] = x[c] + x[d]; x[b] = rotl32(x[b] ^ x[c], 12);
            x[a] = x[a] + x[b]; x[d] = rotl32(x[d] ^ x[a], 8);
            x[c] = x[c] + x[d]; x[b] = rotl32(x[b] ^ x[c], 7);
         end
      end
      for (int i = 0; i < WORDS; i++)
         x[i] = x[i] + init[i];
      return x;
   endfunction

   // Drive one input word, wait for its transfer, update the expected keystream
   task automatic send_word(input logic [31:0] w);
      keystream_word_type kw;
      state16_type        ks;
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_valid   <= 1'b0;
         req_in_word <= $urandom();
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_valid   <= 1'b1;
      req_in_word <= w;
      do @(posedge clock); while (req_stall);
      loaded_words[load_index] = w;
      load_index++;
      if (load_index == WORDS) begin
         ks = chacha_keystream(loaded_words);
         for (int i = 0; i < WORDS; i++) begin
            kw.out_word  = ks[i];
            kw.last_word = (i == WORDS - 1);
            keystream_q.push_back(kw);
         end
         load_index = 0;
      end
   endtask

   // Random blocks; some words forced to all zeros or all ones
   task automatic send_random_blocks(input int n_blocks);
      logic [31:0] w;
      for (int n = 0; n < n_blocks * WORDS; n++) begin
         case ($urandom_range(15))
            0:       w = '0;
            1:       w = '1;
            default: w = $urandom();
         endcase
         send_word(w);
      end
   endtask

   // Result checker and receiver stall generator
   always @(posedge clock) begin : keystream_check
      keystream_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (keystream_q.size() == 0) begin
            $error("unexpected result: out_word %h last_word %b", rsp_out_word, rsp_last_word);
            fail_count++;
         end else begin
            want = keystream_q.pop_front();
            if (rsp_out_word !== want.out_word) begin
               $error("out_word: expected %h, got %h", want.out_word, rsp_out_word);
               fail_count++;
            end
            if (rsp_last_word !== want.last_word) begin
               $error("last_word: expected %b, got %b", want.last_word, rsp_last_word);
               fail_count++;
            end
         end
      end
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // One block of extreme words, with the standard constants up front
   task automatic test_extremes();
      logic [31:0] words [WORDS];
      words = '{32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574,
                32'h00000000, 32'hffffffff, 32'h00000001, 32'h80000000,
                32'h7fffffff, 32'hfffffffe, 32'ha5a5a5a5, 32'h5a5a5a5a,
                32'h00000000, 32'hffffffff, 32'h00000000, 32'hffffffff};
      gap_pct   = 0;
      stall_pct = 0;
      for (int i = 0; i < WORDS; i++)
         send_word(words[i]);
   endtask

   // Back-to-back transfers on both sides
   task automatic test_streaming();
      gap_pct   = 0;
      stall_pct = 0;
      send_random_blocks(7);
   endtask

   task automatic test_sender_gaps();
      gap_pct   = 87;
      stall_pct = 0;
      send_random_blocks(7);
   endtask

   // Receiver stalls back results up, which holds off loading of the next block
   task automatic test_receiver_stalls();
      gap_pct   = 0;
      stall_pct = 87;
      send_random_blocks(7);
   endtask

   task automatic test_both_idle();
      gap_pct   = 6;
      stall_pct = 6;
      send_random_blocks(6);
   endtask

   initial begin
      int waited;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_streaming();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();
      req_valid <= 1'b0;

      // Drain outstanding keystream words
      gap_pct   = 0;
      stall_pct = 0;
      waited    = 0;
      while (keystream_q.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (keystream_q.size() != 0) begin
         $display("[chacha20_block_function] ERROR");
         $finish;
      end else begin
         // Watch for stray results past the last expected one
         repeat (150) @(posedge clock);
         if (fail_count == 0)
            $display("[chacha20_block_function] OK");
         else
            $display("[chacha20_block_function] ERROR");
         $finish;
      end
   end

   // Hard stop in case a handshake hangs
   initial begin
      #5_000_000;
      $display("[chacha20_block_function] ERROR");
      $finish;
   end

endmodule
